// ----- rtl/fqpm_pkg.sv -----
`default_nettype none

package fqpm_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_MAX = 2'd2,
        ACT_CLR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ_WAIT,
        S_SCAN,
        S_SHIFT,
        S_FRONT,
        S_BACK,
        S_BACK_WAIT,
        S_OUT
    } t_state;

    // Storage access command: one write and one read address
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_cmd;

    // Circular slot position: base plus offset, wrapped at DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fqpm_req_if.sv -----
`default_nettype none

interface fqpm_req_if;
    import fqpm_pkg::*;

    logic                     valid;
    logic                     ready;
    t_action                  action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/fqpm_rsp_if.sv -----
`default_nettype none

interface fqpm_rsp_if;
    import fqpm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] removed_value;
    t_status                  status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic                     is_empty;

    modport source (output valid, output removed_value, output status, output count,
                    output front_value, output back_value, output is_empty,
                    input ready);
    modport sink (input valid, input removed_value, input status, input count,
                  input front_value, input back_value, input is_empty,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/fqpm_ram.sv -----
`default_nettype none

module fqpm_ram (
    input  wire logic                      i_clk,
    input  wire fqpm_pkg::t_mem_cmd        i_cmd,
    output logic [fqpm_pkg::DATA_W-1:0]    o_rdata
);
    import fqpm_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write one slot, read one slot with registered data
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        o_rdata <= r_mem[i_cmd.raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/fqpm_seq.sv -----
`default_nettype none

module fqpm_seq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    fqpm_req_if.sink                    i_req,
    fqpm_rsp_if.source                  o_rsp,
    output fqpm_pkg::t_mem_cmd          o_mem_cmd,
    input  wire logic [fqpm_pkg::DATA_W-1:0] i_mem_rdata
);
    import fqpm_pkg::*;

    t_state                   r_state,    n_state;
    t_action                  r_action,   n_action;
    logic [DATA_W-1:0]        r_value,    n_value;
    logic [ADDR_W-1:0]        r_head,     n_head;
    logic [CNT_W-1:0]         r_count,    n_count;
    logic [CNT_W-1:0]         r_k,        n_k;
    logic                     r_rd_vld,   n_rd_vld;
    logic [ADDR_W-1:0]        r_rd_off,   n_rd_off;
    logic [ADDR_W-1:0]        r_best_off, n_best_off;
    logic signed [DATA_W-1:0] r_best_val, n_best_val;
    logic [DATA_W-1:0]        r_removed,  n_removed;
    t_status                  r_status,   n_status;
    logic [DATA_W-1:0]        r_front,    n_front;
    logic [DATA_W-1:0]        r_back,     n_back;

    logic                     in_ready;
    logic                     rd_hit_max;
    logic signed [DATA_W-1:0] rd_data_s;

    assign in_ready  = (r_state == S_IDLE);
    assign rd_data_s = $signed(i_mem_rdata);

    // Shared comparator: first entry seeds the maximum, strictly larger replaces it
    assign rd_hit_max = (r_rd_off == '0) || (rd_data_s > r_best_val);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_value    <= n_value;
        r_k        <= n_k;
        r_rd_off   <= n_rd_off;
        r_best_off <= n_best_off;
        r_best_val <= n_best_val;
        r_removed  <= n_removed;
        r_status   <= n_status;
        r_front    <= n_front;
        r_back     <= n_back;
    end

    // Sequencer: next state, storage access and result capture
    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_value    = r_value;
        n_head     = r_head;
        n_count    = r_count;
        n_k        = r_k;
        n_rd_vld   = 1'b0;
        n_rd_off   = r_rd_off;
        n_best_off = r_best_off;
        n_best_val = r_best_val;
        n_removed  = r_removed;
        n_status   = r_status;
        n_front    = r_front;
        n_back     = r_back;

        o_mem_cmd.we    = 1'b0;
        o_mem_cmd.waddr = r_head;
        o_mem_cmd.wdata = r_value;
        o_mem_cmd.raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_value  = i_req.value;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_removed = '0;
                n_status  = ST_OK;
                n_state   = S_FRONT;
                case (r_action)
                    ACT_ENQ: begin
                        if (r_count >= CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_cmd.we    = 1'b1;
                            o_mem_cmd.waddr = wrap_add(r_head, r_count[ADDR_W-1:0]);
                            n_count         = r_count + CNT_W'(1);
                        end
                    end
                    ACT_DEQ: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_mem_cmd.raddr = r_head;
                            n_rd_vld        = 1'b1;
                            n_rd_off        = '0;
                            n_state         = S_DEQ_WAIT;
                        end
                    end
                    ACT_MAX: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_k     = '0;
                            n_state = S_SCAN;
                        end
                    end
                    ACT_CLR: begin
                        n_head  = '0;
                        n_count = '0;
                    end
                    default: begin
                        n_state = S_FRONT;
                    end
                endcase
            end

            S_DEQ_WAIT: begin
                n_removed = i_mem_rdata;
                n_head    = wrap_add(r_head, ADDR_W'(1));
                n_count   = r_count - CNT_W'(1);
                n_state   = S_FRONT;
            end

            // Stream all entries through the comparator, one read a cycle
            S_SCAN: begin
                if (r_k < r_count) begin
                    o_mem_cmd.raddr = wrap_add(r_head, r_k[ADDR_W-1:0]);
                    n_rd_vld        = 1'b1;
                    n_rd_off        = r_k[ADDR_W-1:0];
                    n_k             = r_k + CNT_W'(1);
                end
                if (r_rd_vld && rd_hit_max) begin
                    n_best_val = rd_data_s;
                    n_best_off = r_rd_off;
                end
                if ((r_k == r_count) && !r_rd_vld) begin
                    n_removed = r_best_val;
                    n_k       = CNT_W'(r_best_off) + CNT_W'(1);
                    n_state   = S_SHIFT;
                end
            end

            // Move each later entry one slot toward the front
            S_SHIFT: begin
                if (r_k < r_count) begin
                    o_mem_cmd.raddr = wrap_add(r_head, r_k[ADDR_W-1:0]);
                    n_rd_vld        = 1'b1;
                    n_rd_off        = r_k[ADDR_W-1:0];
                    n_k             = r_k + CNT_W'(1);
                end
                if (r_rd_vld) begin
                    o_mem_cmd.we    = 1'b1;
                    o_mem_cmd.waddr = wrap_add(r_head, r_rd_off - ADDR_W'(1));
                    o_mem_cmd.wdata = i_mem_rdata;
                end
                if ((r_k == r_count) && !r_rd_vld) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_FRONT;
                end
            end

            S_FRONT: begin
                if (r_count == '0) begin
                    n_front = '0;
                    n_back  = '0;
                    n_state = S_OUT;
                end else begin
                    o_mem_cmd.raddr = r_head;
                    n_rd_vld        = 1'b1;
                    n_rd_off        = '0;
                    n_state         = S_BACK;
                end
            end

            S_BACK: begin
                n_front         = i_mem_rdata;
                n_rd_off        = ADDR_W'(r_count - CNT_W'(1));
                o_mem_cmd.raddr = wrap_add(r_head, n_rd_off);
                n_rd_vld        = 1'b1;
                n_state         = S_BACK_WAIT;
            end

            S_BACK_WAIT: begin
                n_back  = i_mem_rdata;
                n_state = S_OUT;
            end

            // Hold the result until taken
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.status        = r_status;
    assign o_rsp.count         = r_count;
    assign o_rsp.front_value   = r_front;
    assign o_rsp.back_value    = r_back;
    assign o_rsp.is_empty      = (r_count == '0);

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("stored count exceeds depth");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && o_rsp.valid))
        else $error("ready for an item while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready)
        else $error("accepted a second item without finishing the first");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_status == ST_FULL)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_status == ST_EMPTY)) |-> ((r_count == '0) && (r_removed == '0)))
        else $error("empty status with stored values or a removed value");

endmodule

`default_nettype wire

// ----- rtl/fifo_queue_with_pop_max.sv -----
// Channel  | Dir | Handshake   | Payload
// i_req    | in  | valid/ready | action, value
// o_rsp    | out | valid/ready | removed_value, status, count, front_value,
//          |     |             | back_value, is_empty
//
// One item at a time; i_req.ready is high only while idle.
// Each action runs in S_EXEC; the front and back values are then read before the
// result is valid. Remove-maximum first streams every entry through the single
// comparator, one storage read per cycle, then closes the gap with one read and one
// write per cycle. The block is idle again in the cycle after the result is taken.
// A pending result holds until o_rsp.ready; i_rst_n empties the queue.
`default_nettype none

module fifo_queue_with_pop_max (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fqpm_req_if.sink   i_req,
    fqpm_rsp_if.source o_rsp
);
    import fqpm_pkg::*;

    t_mem_cmd          mem_cmd;
    logic [DATA_W-1:0] mem_rdata;

    // Sequencer with shared comparator
    fqpm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_cmd   (mem_cmd),
        .i_mem_rdata (mem_rdata)
    );

    // Slot storage
    fqpm_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
